// ===== hdl/graph_level_topological_sort_core_macros.svh =====
// Assertion macros for the level sort core.
// Included by the top level; no other dependencies.
`ifndef GRAPH_LEVEL_TOPOLOGICAL_SORT_CORE_MACROS_SVH
`define GRAPH_LEVEL_TOPOLOGICAL_SORT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GLTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GLTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/glts_pkg.sv =====
// Shared types and constants for the level sort core.
// No dependencies.
package glts_pkg;
    localparam int NODES_DEFAULT = 32;
    localparam int EDGE_COUNT_MAX_DEFAULT = 15;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LINK   = 2'd1;
    localparam logic [1:0] CMD_UNLINK = 2'd2;
    localparam logic [1:0] CMD_SORT   = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_NODE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CYCLE     = 3'd3;
    localparam logic [2:0] ST_ABSENT    = 3'd4;
    localparam logic [2:0] ST_SATURATED = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SEARCH, S_EDGE_RD, S_EDGE_WAIT, S_EDGE_WR,
        S_DEG_CLR, S_DEG_RD, S_DEG_ACC, S_LVL, S_SCAN, S_SUB_RD, S_SUB_ACC,
        S_EMIT, S_END
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_in;      // capture input transaction
        logic clr_step;     // write zero at cnt, advance cnt
        logic cnt_zero;     // cnt <= 0
        logic cnt_inc;      // cnt <= cnt + 1
        logic srch_step;    // compare node at cnt against a and b
        logic add_node;     // store value_a, bump total
        logic edge_rd;      // read edge[a][b]
        logic edge_wr;      // write updated count
        logic deg_clr;      // clear in-degrees and done mask
        logic deg_rd;       // read edge[cnt][d] (d = sub index)
        logic deg_acc;      // add read count into degree of d
        logic lvl_make;     // build level mask
        logic scan_next;    // move scan pointer to next level member
        logic sub_rd;       // read edge[s][d]
        logic sub_acc;      // subtract read count from degree of d
        logic sub_inc;      // advance d
        logic sub_zero;     // d <= 0
        logic level_inc;    // next level
        logic out_node;     // load sorted node result
        logic out_ack;      // load acknowledge result
        logic out_end;      // load end result
    } ctrl_t;

    typedef struct packed {
        logic cnt_last;     // cnt at final index of its sweep
        logic sub_last;     // d at n-1 (or n is zero)
        logic found_both;   // both searches hit
        logic lvl_empty;    // level mask is empty
        logic scan_done;    // no remaining member in level
        logic full;         // table full
        logic [1:0] cmd;    // captured command
        logic out_busy;     // output register holds a result
    } stat_t;
endpackage

// ===== hdl/glts_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// No dependencies.
interface glts_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/glts_datapath.sv =====
// Datapath: node table, edge count memory, degrees, masks and output register.
// Depends on glts_pkg.
module glts_datapath #(
    parameter int NODES = 32,
    parameter int EDGE_COUNT_MAX = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  glts_pkg::ctrl_t     ctrl,
    output glts_pkg::stat_t     stat,
    input  logic [1:0]          in_command,
    input  logic [31:0]         in_value_a,
    input  logic [31:0]         in_value_b,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [1:0]          out_kind,
    output logic [2:0]          out_status,
    output logic [31:0]         out_node_value,
    output logic [5:0]          out_level,
    output logic                out_last
);
    import glts_pkg::*;
    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int KW = ((AW > CW) ? AW : CW) + 1;
    localparam int EW = $clog2(EDGE_COUNT_MAX + 1);
    localparam int DW = $clog2(NODES * EDGE_COUNT_MAX + 1);

    logic [31:0] node_mem [NODES];
    logic [EW-1:0] edge_mem [DEPTH];
    logic [1:0]  cmd_reg;
    logic [31:0] va_reg, vb_reg;
    logic [CW-1:0] total_reg;
    logic [KW-1:0] cnt_reg;
    logic [IW-1:0] ia_reg, ib_reg, s_reg;
    logic [CW-1:0] d_reg;
    logic fa_reg, fb_reg;
    logic [EW-1:0] erd_reg;
    logic [DW-1:0] deg_reg [NODES];
    logic [NODES-1:0] done_reg, lvl_reg;
    logic [5:0] level_reg;
    logic [CW-1:0] placed_reg;
    logic [31:0] nrd_reg;
    logic [2:0] ack_st;
    logic out_valid_reg;
    logic [1:0] kind_reg;
    logic [2:0] status_reg;
    logic [31:0] val_reg;
    logic [5:0] olevel_reg;
    logic last_reg;
    logic [NODES-1:0] lvl_next, rem;
    logic [AW-1:0] rd_addr;
    logic [IW-1:0] s_pick;
    logic any_rem;

    // Edge address: row = source, column = destination.
    always_comb
    begin
        rd_addr = {ia_reg, ib_reg};
        if (ctrl.deg_rd)
            rd_addr = {cnt_reg[IW-1:0], d_reg[IW-1:0]};
        else if (ctrl.sub_rd)
            rd_addr = {s_reg, d_reg[IW-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.edge_rd || ctrl.deg_rd || ctrl.sub_rd)
            erd_reg <= edge_mem[rd_addr];
        if (ctrl.clr_step)
            edge_mem[cnt_reg[AW-1:0]] <= '0;
        else if (ctrl.edge_wr && ack_st == ST_OK)
            edge_mem[{ia_reg, ib_reg}] <= (cmd_reg == CMD_LINK) ? erd_reg + EW'(1)
                                                                : erd_reg - EW'(1);
        if (ctrl.add_node && total_reg != CW'(NODES))
            node_mem[total_reg[IW-1:0]] <= va_reg;
        if (ctrl.scan_next)
            nrd_reg <= node_mem[s_pick];
    end

    always_comb
    begin
        ack_st = ST_OK;
        if (cmd_reg == CMD_LINK && erd_reg >= EW'(EDGE_COUNT_MAX))
            ack_st = ST_SATURATED;
        else if (cmd_reg == CMD_UNLINK && erd_reg == '0)
            ack_st = ST_ABSENT;
    end

    // Level mask: not done, in-degree zero, below total.
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
            lvl_next[i] = (CW'(i) < total_reg) && !done_reg[i] && (deg_reg[i] == '0);
    end

    // Next level member at or after the current one, lowest index first.
    always_comb
    begin
        rem = lvl_reg & done_reg ^ lvl_reg;
        s_pick = s_reg;
        any_rem = 1'b0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (rem[i])
            begin
                s_pick = IW'(i);
                any_rem = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            done_reg <= '0;
            lvl_reg <= '0;
            level_reg <= '0;
            placed_reg <= '0;
            d_reg <= '0;
            s_reg <= '0;
            fa_reg <= 1'b0;
            fb_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (ctrl.load_in)
            begin
                cmd_reg <= in_command;
                va_reg <= in_value_a;
                vb_reg <= in_value_b;
                fa_reg <= 1'b0;
                fb_reg <= 1'b0;
            end
            if (ctrl.cnt_zero)
                cnt_reg <= '0;
            else if (ctrl.cnt_inc || ctrl.clr_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (ctrl.srch_step && cnt_reg[CW-1:0] < total_reg)
            begin
                if (!fa_reg && node_mem[cnt_reg[IW-1:0]] == va_reg)
                begin
                    fa_reg <= 1'b1;
                    ia_reg <= cnt_reg[IW-1:0];
                end
                if (!fb_reg && node_mem[cnt_reg[IW-1:0]] == vb_reg)
                begin
                    fb_reg <= 1'b1;
                    ib_reg <= cnt_reg[IW-1:0];
                end
            end
            if (ctrl.add_node && total_reg != CW'(NODES))
                total_reg <= total_reg + 1'b1;
            if (ctrl.deg_clr)
            begin
                for (int i = 0; i < NODES; i++)
                    deg_reg[i] <= '0;
                done_reg <= '0;
                lvl_reg <= '0;
                level_reg <= '0;
                placed_reg <= '0;
            end
            if (ctrl.deg_acc)
                deg_reg[d_reg[IW-1:0]] <= deg_reg[d_reg[IW-1:0]] + DW'(erd_reg);
            if (ctrl.sub_acc)
                deg_reg[d_reg[IW-1:0]] <= (deg_reg[d_reg[IW-1:0]] >= DW'(erd_reg))
                    ? deg_reg[d_reg[IW-1:0]] - DW'(erd_reg) : '0;
            if (ctrl.sub_zero)
                d_reg <= '0;
            else if (ctrl.sub_inc)
                d_reg <= d_reg + 1'b1;
            if (ctrl.lvl_make)
                lvl_reg <= lvl_next;
            if (ctrl.scan_next)
            begin
                s_reg <= s_pick;
                done_reg[s_pick] <= 1'b1;
                placed_reg <= placed_reg + 1'b1;
            end
            if (ctrl.level_inc)
                level_reg <= level_reg + 1'b1;
            if (ctrl.out_ack || ctrl.out_node || ctrl.out_end)
                out_valid_reg <= 1'b1;
            if (ctrl.out_ack)
            begin
                kind_reg <= KIND_ACK;
                val_reg <= '0;
                olevel_reg <= '0;
                last_reg <= 1'b1;
                if (cmd_reg == CMD_ADD)
                    status_reg <= (total_reg == CW'(NODES)) ? ST_FULL : ST_OK;
                else if (!(fa_reg && fb_reg))
                    status_reg <= ST_NOT_FOUND;
                else
                    status_reg <= ack_st;
            end
            if (ctrl.out_node)
            begin
                kind_reg <= KIND_NODE;
                status_reg <= ST_OK;
                val_reg <= nrd_reg;
                olevel_reg <= level_reg;
                last_reg <= 1'b0;
            end
            if (ctrl.out_end)
            begin
                kind_reg <= KIND_END;
                status_reg <= (placed_reg == total_reg) ? ST_OK : ST_CYCLE;
                val_reg <= '0;
                olevel_reg <= level_reg;
                last_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.cnt_last = 1'b0;
        stat.sub_last = (d_reg + 1'b1 >= total_reg);
        stat.found_both = fa_reg && fb_reg;
        stat.lvl_empty = (lvl_next == '0);
        stat.scan_done = !any_rem;
        stat.full = (total_reg == CW'(NODES));
        stat.cmd = cmd_reg;
        stat.out_busy = out_valid_reg;
        if (ctrl.clr_step)
            stat.cnt_last = (cnt_reg == KW'(DEPTH - 1)) || cnt_reg[AW];
        else
            stat.cnt_last = (cnt_reg[CW-1:0] + 1'b1 >= total_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_kind = kind_reg;
    assign out_status = status_reg;
    assign out_node_value = val_reg;
    assign out_level = olevel_reg;
    assign out_last = last_reg;
endmodule

// ===== hdl/glts_ctrl.sv =====
// Controller state machine sequencing commands through the datapath.
// Depends on glts_pkg.
module glts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  glts_pkg::stat_t stat,
    output glts_pkg::ctrl_t ctrl,
    output glts_pkg::state_t state
);
    import glts_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.cnt_last)
                begin
                    ctrl.cnt_zero = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_in = 1'b1;
                    ctrl.cnt_zero = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.cmd == CMD_ADD)
                begin
                    if (!stat.out_busy)
                    begin
                        ctrl.out_ack = 1'b1;
                        ctrl.add_node = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.cmd == CMD_SORT)
                begin
                    ctrl.deg_clr = 1'b1;
                    ctrl.sub_zero = 1'b1;
                    state_next = S_DEG_CLR;
                end
                else
                begin
                    ctrl.srch_step = 1'b1;
                    ctrl.cnt_inc = 1'b1;
                    if (stat.cnt_last)
                        state_next = S_EDGE_RD;
                end
            end
            S_EDGE_RD:
            begin
                ctrl.edge_rd = 1'b1;
                state_next = S_EDGE_WAIT;
            end
            S_EDGE_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.out_ack = 1'b1;
                    ctrl.edge_wr = stat.found_both;
                    state_next = S_IDLE;
                end
            end
            S_DEG_CLR:
            begin
                // An empty table still takes one harmless pass over entry zero,
                // which can never have been linked.
                state_next = S_DEG_RD;
            end
            S_DEG_RD:
            begin
                ctrl.deg_rd = 1'b1;
                state_next = S_DEG_ACC;
            end
            S_DEG_ACC:
            begin
                ctrl.deg_acc = 1'b1;
                if (stat.sub_last)
                begin
                    ctrl.sub_zero = 1'b1;
                    ctrl.cnt_inc = 1'b1;
                    state_next = stat.cnt_last ? S_LVL : S_DEG_RD;
                end
                else
                begin
                    ctrl.sub_inc = 1'b1;
                    state_next = S_DEG_RD;
                end
            end
            S_LVL:
            begin
                ctrl.lvl_make = 1'b1;
                state_next = stat.lvl_empty ? S_END : S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    ctrl.level_inc = 1'b1;
                    state_next = S_LVL;
                end
                else
                begin
                    ctrl.scan_next = 1'b1;
                    ctrl.sub_zero = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.out_node = 1'b1;
                    state_next = S_SUB_RD;
                end
            end
            S_SUB_RD:
            begin
                ctrl.sub_rd = 1'b1;
                state_next = S_SUB_ACC;
            end
            S_SUB_ACC:
            begin
                ctrl.sub_acc = 1'b1;
                if (stat.sub_last)
                    state_next = S_SCAN;
                else
                begin
                    ctrl.sub_inc = 1'b1;
                    state_next = S_SUB_RD;
                end
            end
            S_END:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.out_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign state = state_reg;
endmodule

// ===== hdl/graph_level_topological_sort_core.sv =====
// Top level of the level sort core: controller, datapath and assertions.
// Depends on glts_pkg, glts_if, glts_ctrl, glts_datapath and the macro header.
//
// Usage. Commands arrive on the cmd sink channel (command, value_a, value_b);
// results leave on the res source channel (kind, status, node_value, level,
// last). A transaction is accepted when valid and ready are both high.
// The block takes one command at a time. Link and unlink run a sequential
// search over the node table and one read-modify-write of the edge memory.
// Sort accumulates in-degrees over the edge count memory, then updates the
// degrees of each placed node's successors, all paced by the single read
// port of the edge count memory, and emits one transaction per placed
// node followed by an end transaction with last set.
// After reset all 2^(2 * ceil(log2(NODES))) entries of the edge count
// memory are cleared, one entry a cycle, 1024 entries at the default of
// 32 nodes; commands are not accepted during that pass.
// A stalled receiver holds the result register; the controller waits until
// it drains before producing the next result, so nothing is lost.
`include "graph_level_topological_sort_core_macros.svh"
module graph_level_topological_sort_core #(
    parameter int NODES = glts_pkg::NODES_DEFAULT,
    parameter int EDGE_COUNT_MAX = glts_pkg::EDGE_COUNT_MAX_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    glts_if.sink   cmd,
    glts_if.source res
);
    import glts_pkg::*;
    ctrl_t ctrl;
    stat_t stat;
    state_t state;

    glts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(cmd.valid), .in_ready(cmd.ready),
        .stat(stat), .ctrl(ctrl), .state(state)
    );

    glts_datapath #(.NODES(NODES), .EDGE_COUNT_MAX(EDGE_COUNT_MAX)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .in_command(cmd.data.command), .in_value_a(cmd.data.value_a),
        .in_value_b(cmd.data.value_b),
        .out_ready(res.ready), .out_valid(res.valid),
        .out_kind(res.data.kind), .out_status(res.data.status),
        .out_node_value(res.data.node_value), .out_level(res.data.level),
        .out_last(res.data.last)
    );

    // Commands are only taken while the controller is idle.
    `GLTS_ASSERT_IMPL(a_ready_idle, clk, rst_n, cmd.ready, state == S_IDLE)
    // A new result is never loaded over one that has not been taken.
    `GLTS_ASSERT_IMPL(a_no_overwrite, clk, rst_n, res.valid && !res.ready, !(ctrl.out_ack || ctrl.out_node || ctrl.out_end))
    // An accepted command always leaves the idle state.
    `GLTS_ASSERT_NEXT(a_cmd_leaves, clk, rst_n, cmd.valid && cmd.ready, state == S_SEARCH)
endmodule

// ===== test/tb_graph_level_topological_sort_core.sv =====
// Self-checking testbench for the level sort core: random and directed graph commands.
// Depends on glts_pkg, glts_if and graph_level_topological_sort_core from the RTL.
module tb_graph_level_topological_sort_core;
    timeunit 1ns;
    timeprecision 1ps;
    import glts_pkg::*;

    localparam int NODES = 32;
    localparam int EDGE_MAX = 15;
    localparam int RANDOM_ITEMS = 480;
    // Cycles without any transaction before the run is abandoned.
    localparam int STALL_LIMIT = 50000;

    // Payload layouts of the command and result channels.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value_a;
        logic [31:0] value_b;
    } command_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] node_value;
        logic [5:0]  level;
        logic        last;
    } result_t;

    logic clk;
    logic rst_n;

    glts_if #(.T(command_t)) cmd ();
    glts_if #(.T(result_t))  res ();

    graph_level_topological_sort_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Commands waiting to be offered, and results predicted but not yet seen.
    command_t pending_cmds[$];
    result_t  awaited_results[$];

    int total_cmds;
    int cmds_accepted;
    int results_accepted;
    int mismatches;
    int quiet_cycles;
    bit holdoff_done;
    int holdoff_left;

    // Shadow of the graph, updated as each command transaction is accepted.
    logic [31:0] shadow_values[NODES];
    int          shadow_total;
    logic [3:0]  shadow_edges[NODES][NODES];

    // Mirror of the node table used only while the stimulus is generated.
    logic [31:0] gen_values[$];

    // Idling phase follows how far through the stimulus the sender is: first the
    // sender idles rarely and the receiver often, then the reverse, then neither.
    function automatic int idle_phase();
        return (total_cmds == 0) ? 2 : (cmds_accepted * 3) / total_cmds;
    endfunction

    function automatic int find_lowest(logic [31:0] v);
        for (int i = 0; i < shadow_total; i++)
            if (shadow_values[i] == v)
                return i;
        return -1;
    endfunction

    function automatic result_t make_result(logic [1:0] kind, logic [2:0] status,
                                            logic [31:0] value, logic [5:0] level,
                                            logic last);
        result_t r;
        r.kind = kind;
        r.status = status;
        r.node_value = value;
        r.level = level;
        r.last = last;
        return r;
    endfunction

    // Kahn's algorithm by levels on a scratch copy of the in-degrees. Nodes of
    // one level come out in ascending index order; the closing transaction
    // carries the level count and flags a cycle when some node was never placed.
    task automatic predict_sort();
        int indeg[NODES];
        bit placed_flag[NODES];
        bit in_level[NODES];
        int placed;
        int levels;
        bit any;
        placed = 0;
        levels = 0;
        for (int d = 0; d < NODES; d++)
        begin
            indeg[d] = 0;
            placed_flag[d] = 1'b0;
            for (int s = 0; s < shadow_total; s++)
                indeg[d] += shadow_edges[s][d];
        end
        forever
        begin
            any = 1'b0;
            for (int d = 0; d < shadow_total; d++)
            begin
                in_level[d] = !placed_flag[d] && indeg[d] == 0;
                any |= in_level[d];
            end
            if (!any)
                break;
            for (int s = 0; s < shadow_total; s++)
            begin
                if (!in_level[s])
                    continue;
                awaited_results.push_back(make_result(KIND_NODE, ST_OK, shadow_values[s],
                                                      6'(levels), 1'b0));
                placed++;
                placed_flag[s] = 1'b1;
                for (int d = 0; d < shadow_total; d++)
                    indeg[d] = (indeg[d] >= shadow_edges[s][d]) ?
                               indeg[d] - shadow_edges[s][d] : 0;
            end
            levels++;
        end
        awaited_results.push_back(make_result(KIND_END,
                                              placed == shadow_total ? ST_OK : ST_CYCLE,
                                              32'd0, 6'(levels), 1'b1));
    endtask

    task automatic predict_command(command_t c);
        logic [2:0] status;
        int a;
        int b;
        status = ST_OK;
        if (c.command == CMD_SORT)
        begin
            predict_sort();
            return;
        end
        if (c.command == CMD_ADD)
        begin
            if (shadow_total >= NODES)
                status = ST_FULL;
            else
            begin
                shadow_values[shadow_total] = c.value_a;
                shadow_total++;
            end
        end
        else
        begin
            a = find_lowest(c.value_a);
            b = find_lowest(c.value_b);
            if (a < 0 || b < 0)
                status = ST_NOT_FOUND;
            else if (c.command == CMD_LINK)
            begin
                if (shadow_edges[a][b] >= EDGE_MAX)
                    status = ST_SATURATED;
                else
                    shadow_edges[a][b]++;
            end
            else if (shadow_edges[a][b] == 0)
                status = ST_ABSENT;
            else
                shadow_edges[a][b]--;
        end
        awaited_results.push_back(make_result(KIND_ACK, status, 32'd0, 6'd0, 1'b1));
    endtask

    // Queues a command; adds are mirrored so later links can name stored nodes.
    task automatic queue_command(logic [1:0] op, logic [31:0] va, logic [31:0] vb);
        command_t c;
        c.command = op;
        c.value_a = va;
        c.value_b = vb;
        if (op == CMD_ADD && gen_values.size() < NODES)
            gen_values.push_back(va);
        pending_cmds.push_back(c);
    endtask

    // A stored value most of the time, otherwise a fresh random one.
    function automatic logic [31:0] pick_value();
        if (gen_values.size() > 0 && $urandom_range(9) < 8)
            return gen_values[$urandom_range(gen_values.size() - 1)];
        return $urandom;
    endfunction

    // Driver: offers the next queued command, holding it until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.data  <= '0;
        end
        else if (!cmd.valid || cmd.ready)
        begin
            if (pending_cmds.size() > 0 &&
                !(idle_phase() == 0 && $urandom_range(99) < 7) &&
                !(idle_phase() == 1 && $urandom_range(99) < 46))
            begin
                cmd.valid <= 1'b1;
                cmd.data  <= pending_cmds.pop_front();
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // Receiver readiness. One long hold-off is taken early, with the sender
    // still offering, so that the result register fills and the input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready    <= 1'b0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            res.ready    <= 1'b0;
        end
        else if (!holdoff_done && results_accepted >= 40)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= 400;
            res.ready    <= 1'b0;
        end
        else if (idle_phase() == 0)
            res.ready <= $urandom_range(99) >= 46;
        else if (idle_phase() == 1)
            res.ready <= $urandom_range(99) >= 7;
        else
            res.ready <= 1'b1;
    end

    // Monitor: predicts on each accepted command, then checks each accepted
    // result against the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                cmds_accepted <= cmds_accepted + 1;
                predict_command(cmd.data);
            end
            if (res.valid && res.ready)
            begin
                results_accepted <= results_accepted + 1;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction %p", res.data);
                end
                else if (res.data !== awaited_results[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p",
                                 awaited_results[0], res.data);
                    void'(awaited_results.pop_front());
                end
                else
                    void'(awaited_results.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("graph_level_topological_sort_core test failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int i;
        int j;
        logic [31:0] va;
        logic [31:0] vb;
        rst_n = 1'b0;
        cmds_accepted = 0;
        results_accepted = 0;
        mismatches = 0;
        quiet_cycles = 0;
        shadow_total = 0;
        total_cmds = 0;
        for (int s = 0; s < NODES; s++)
            for (int d = 0; d < NODES; d++)
                shadow_edges[s][d] = '0;

        // Directed part: sort of an empty graph, missing nodes, extreme and
        // duplicate values, a saturating edge, an absent edge and a self loop.
        queue_command(CMD_SORT, 32'd0, 32'd0);
        queue_command(CMD_UNLINK, 32'd5, 32'd6);
        queue_command(CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_command(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_command(CMD_ADD, 32'h0000_0000, 32'd0);
        queue_command(CMD_ADD, 32'h5A5A_A5A5, 32'd0);
        queue_command(CMD_LINK, 32'd1, 32'h0000_0000);
        for (int k = 0; k < EDGE_MAX + 1; k++)
            queue_command(CMD_LINK, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_command(CMD_UNLINK, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_command(CMD_LINK, 32'h5A5A_A5A5, 32'h5A5A_A5A5);
        queue_command(CMD_SORT, 32'd0, 32'd0);
        queue_command(CMD_UNLINK, 32'h5A5A_A5A5, 32'h5A5A_A5A5);
        queue_command(CMD_SORT, 32'd0, 32'd0);

        // Random part. Links mostly run from lower to higher index, so that the
        // graph stays mostly acyclic and sorts reach several levels.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            r = $urandom_range(99);
            if (r < 12)
                queue_command(CMD_ADD, $urandom_range(3) == 0 ? pick_value() : $urandom,
                              $urandom);
            else if (r < 93 && gen_values.size() > 1 && $urandom_range(9) < 8)
            begin
                i = $urandom_range(gen_values.size() - 2);
                j = $urandom_range(gen_values.size() - 1, i + 1);
                if ($urandom_range(19) == 0)
                    j = $urandom_range(i);
                va = gen_values[i];
                vb = gen_values[j];
                queue_command(r < 62 ? CMD_LINK : CMD_UNLINK, va, vb);
            end
            else if (r < 93)
                queue_command(r < 62 ? CMD_LINK : CMD_UNLINK, pick_value(), pick_value());
            else
                queue_command(CMD_SORT, $urandom, $urandom);
        end
        queue_command(CMD_SORT, 32'd0, 32'd0);
        total_cmds = pending_cmds.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_cmds.size() > 0 || cmd.valid || awaited_results.size() > 0);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("graph_level_topological_sort_core test passed");
        else
            $display("graph_level_topological_sort_core test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/glts_pkg.sv
hdl/glts_if.sv
hdl/glts_datapath.sv
hdl/glts_ctrl.sv
hdl/graph_level_topological_sort_core.sv
test/tb_graph_level_topological_sort_core.sv
